// File: rtl/core/abkf_pkg.sv
// abkf_pkg: shared types, constants and helpers for the angle/bias kalman filter
// no dependencies; used by abkf_div and angle_bias_kalman_filter
package abkf_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int DIV_STEPS  = 33;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_MEASURE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 8'd3;

    localparam logic [23:0] Q_ANGLE_RESET   = 24'd16777;
    localparam logic [23:0] Q_BIAS_RESET    = 24'd50332;
    localparam logic [23:0] R_MEASURE_RESET = 24'd503316;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_ANG,   ST_W_ANG,
        ST_M_T,     ST_W_T,
        ST_M_P00,   ST_W_P00,
        ST_W_P0110,
        ST_M_P11,   ST_W_P11,
        ST_INNOV,
        ST_DIV0_GO, ST_DIV0_WAIT,
        ST_DIV1_GO, ST_DIV1_WAIT,
        ST_M_AY,    ST_W_AY,
        ST_M_BY,    ST_W_BY,
        ST_M_C10,   ST_W_C10,
        ST_M_C11,   ST_W_C11,
        ST_M_C01,   ST_W_C01,
        ST_M_C00,   ST_W_C00,
        ST_DONE
    } abkf_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_PRE,
        DV_RUN,
        DV_DONE
    } abkf_div_state_t;

    // request into the divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] numer;
        logic [31:0]        denom;
    } abkf_div_req_t;

    // saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
        logic signed [31:0] r;
        if (x > 46'(S32_MAX)) begin
            r = S32_MAX;
        end else if (x < 46'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/angle_bias_kalman_filter.sv
// angle_bias_kalman_filter: two-state kalman filter for angle and gyro bias, top level
// depends on abkf_pkg and abkf_div
//
// Each item carries an accelerometer angle and a gyro rate (signed Q16.16) and a time
// step (unsigned Q0.24); the block predicts, corrects and returns the new angle as one
// result item. Covariance and gains are signed Q8.24, every stored value saturates to
// 32 bits. All products go through one shared 35x33 multiplier with a registered
// product, each multiply having an issue step and a round-and-write-back step; the two
// gains come from a bit-serial divider. The time per item is dominated by the two
// divisions; when the innovation covariance P00 + R is not positive the gains are zero
// and both divisions are skipped. s_ready is high only while the sequencer is idle; the
// result sits in an output register so the next item can be taken while it waits, and a
// second result stalls in the last step until that register is read. Configuration
// writes are always accepted and are meant to be issued only while the block is idle;
// writing start_angle also loads the angle estimate.
module angle_bias_kalman_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_accel_angle,
    input  logic signed [31:0]                s_gyro_speed,
    input  logic [23:0]                       s_time_step,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_angle_estimate,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abkf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import abkf_pkg::*;

    abkf_state_t state_reg, state_next;

    // configuration
    logic [23:0]        q_angle_reg;
    logic [23:0]        q_bias_reg;
    logic [23:0]        r_meas_reg;

    // filter state
    logic signed [31:0] angle_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // captured item and working values
    logic signed [31:0] acc_reg;
    logic signed [31:0] gyro_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] y_reg;
    logic [31:0]        s_reg;
    logic               s_pos_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [67:0] prod_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_angle_reg;

    // shared multiplier and write-back path
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [31:0] wb_base;
    logic               wb_neg;
    logic signed [45:0] rnd;
    logic signed [45:0] wb_sum;
    logic signed [31:0] wb_sat;
    logic signed [34:0] inner;
    logic signed [32:0] s_full;

    abkf_div_req_t      div_req;
    logic               div_done;
    logic signed [31:0] div_quot;

    logic cfg_we;
    logic s_acc;
    logic dt_is_b;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign m_valid   = m_valid_reg;
    assign m_angle_estimate = m_angle_reg;

    // angle covariance term, kept exact before the multiply by dt
    assign inner = 35'(t_reg) - 35'(p01_reg) - 35'(p10_reg) + $signed({11'd0, q_angle_reg});
    assign s_full = 33'(p00_reg) + $signed({9'd0, r_meas_reg});

    // product back to Q format with round half up, then add or subtract
    assign rnd    = 46'($signed(prod_reg[67:FRAC_BITS]))
                  + $signed({45'd0, prod_reg[FRAC_BITS-1]});
    assign wb_sum = wb_neg ? (46'(wb_base) - rnd) : (46'(wb_base) + rnd);
    assign wb_sat = sat32(wb_sum);

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_acc) state_next = ST_RATE;
            ST_RATE:      state_next = ST_M_ANG;
            ST_M_ANG:     state_next = ST_W_ANG;
            ST_W_ANG:     state_next = ST_M_T;
            ST_M_T:       state_next = ST_W_T;
            ST_W_T:       state_next = ST_M_P00;
            ST_M_P00:     state_next = ST_W_P00;
            ST_W_P00:     state_next = ST_W_P0110;
            ST_W_P0110:   state_next = ST_M_P11;
            ST_M_P11:     state_next = ST_W_P11;
            ST_W_P11:     state_next = ST_INNOV;
            ST_INNOV:     state_next = ST_DIV0_GO;
            ST_DIV0_GO:   state_next = s_pos_reg ? ST_DIV0_WAIT : ST_M_AY;
            ST_DIV0_WAIT: if (div_done) state_next = ST_DIV1_GO;
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_done) state_next = ST_M_AY;
            ST_M_AY:      state_next = ST_W_AY;
            ST_W_AY:      state_next = ST_M_BY;
            ST_M_BY:      state_next = ST_W_BY;
            ST_W_BY:      state_next = ST_M_C10;
            ST_M_C10:     state_next = ST_W_C10;
            ST_W_C10:     state_next = ST_M_C11;
            ST_M_C11:     state_next = ST_W_C11;
            ST_W_C11:     state_next = ST_M_C01;
            ST_M_C01:     state_next = ST_W_C01;
            ST_W_C01:     state_next = ST_M_C00;
            ST_M_C00:     state_next = ST_W_C00;
            ST_W_C00:     state_next = ST_DONE;
            // wait for the output register to free up
            ST_DONE:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // multiplier operands, write-back base and divider request per step
    always_comb begin
        mul_a   = '0;
        dt_is_b = 1'b0;
        mul_en  = 1'b0;
        wb_base = '0;
        wb_neg  = 1'b0;
        div_req = '{start: 1'b0, numer: p00_reg, denom: s_reg};
        unique case (state_reg)
            ST_M_ANG:   begin mul_a = 35'(rate_reg); dt_is_b = 1'b1; mul_en = 1'b1; end
            ST_M_T:     begin mul_a = 35'(p11_reg);  dt_is_b = 1'b1; mul_en = 1'b1; end
            ST_M_P00:   begin mul_a = inner;         dt_is_b = 1'b1; mul_en = 1'b1; end
            ST_M_P11:   begin
                mul_a = $signed({11'd0, q_bias_reg}); dt_is_b = 1'b1; mul_en = 1'b1;
            end
            ST_M_AY:    begin mul_a = 35'(y_reg);    mul_en = 1'b1; end
            ST_M_BY:    begin mul_a = 35'(y_reg);    mul_en = 1'b1; end
            ST_M_C10:   begin mul_a = 35'(p00_reg);  mul_en = 1'b1; end
            ST_M_C11:   begin mul_a = 35'(p01_reg);  mul_en = 1'b1; end
            ST_M_C01:   begin mul_a = 35'(p01_reg);  mul_en = 1'b1; end
            ST_M_C00:   begin mul_a = 35'(p00_reg);  mul_en = 1'b1; end
            ST_W_ANG:   wb_base = angle_reg;
            ST_W_P00:   wb_base = p00_reg;
            ST_W_P11:   wb_base = p11_reg;
            ST_W_AY:    wb_base = angle_reg;
            ST_W_BY:    wb_base = bias_reg;
            ST_W_C10:   begin wb_base = p10_reg; wb_neg = 1'b1; end
            ST_W_C11:   begin wb_base = p11_reg; wb_neg = 1'b1; end
            ST_W_C01:   begin wb_base = p01_reg; wb_neg = 1'b1; end
            ST_W_C00:   begin wb_base = p00_reg; wb_neg = 1'b1; end
            ST_DIV0_GO: div_req = '{start: s_pos_reg, numer: p00_reg, denom: s_reg};
            ST_DIV1_GO: div_req = '{start: 1'b1,      numer: p10_reg, denom: s_reg};
            default: begin
            end
        endcase
        // dt for the prediction, the k0 or k1 gain for the correction products
        if (dt_is_b) begin
            mul_b = $signed({9'd0, dt_reg});
        end else if (state_reg == ST_M_AY || state_reg == ST_M_C01 || state_reg == ST_M_C00) begin
            mul_b = 33'(k0_reg);
        end else begin
            mul_b = 33'(k1_reg);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_angle_reg     <= Q_ANGLE_RESET;
            q_bias_reg      <= Q_BIAS_RESET;
            r_meas_reg      <= R_MEASURE_RESET;
            angle_reg       <= '0;
            bias_reg        <= '0;
            p00_reg         <= '0;
            p01_reg         <= '0;
            p10_reg         <= '0;
            p11_reg         <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_Q_ANGLE)   q_angle_reg <= cfg_data[23:0];
                if (cfg_index == REG_Q_BIAS)    q_bias_reg  <= cfg_data[23:0];
                if (cfg_index == REG_R_MEASURE) r_meas_reg  <= cfg_data[23:0];
            end
            if (cfg_we && cfg_index == REG_START_ANGLE) begin
                angle_reg       <= $signed(cfg_data);
            end else if (state_reg == ST_W_ANG || state_reg == ST_W_AY) begin
                angle_reg <= wb_sat;
            end
            unique case (state_reg)
                ST_W_BY:    bias_reg <= wb_sat;
                ST_W_P00:   p00_reg  <= wb_sat;
                // both off-diagonal terms drop by dt*P11
                ST_W_P0110: begin
                    p01_reg <= sat32(46'(p01_reg) - 46'(t_reg));
                    p10_reg <= sat32(46'(p10_reg) - 46'(t_reg));
                end
                ST_W_P11:   p11_reg  <= wb_sat;
                ST_W_C10:   p10_reg  <= wb_sat;
                ST_W_C11:   p11_reg  <= wb_sat;
                ST_W_C01:   p01_reg  <= wb_sat;
                ST_W_C00:   p00_reg  <= wb_sat;
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            acc_reg  <= s_accel_angle;
            gyro_reg <= s_gyro_speed;
            dt_reg   <= s_time_step;
        end
        if (mul_en) begin
            prod_reg <= 68'(mul_a) * 68'(mul_b);
        end
        unique case (state_reg)
            ST_RATE:  rate_reg <= sat32(46'(gyro_reg) - 46'(bias_reg));
            ST_W_T:   t_reg    <= wb_sat;
            ST_INNOV: begin
                y_reg     <= sat32(46'(acc_reg) - 46'(angle_reg));
                s_reg     <= s_full[31:0];
                s_pos_reg <= s_full > 33'sd0;
                k0_reg    <= '0;
                k1_reg    <= '0;
            end
            ST_DIV0_WAIT: if (div_done) k0_reg <= div_quot;
            ST_DIV1_WAIT: if (div_done) k1_reg <= div_quot;
            ST_DONE:  if (!m_valid_reg || m_ready) m_angle_reg <= angle_reg;
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/abkf_div.sv
// abkf_div: bit-serial gain divider, round(numer * 2^24 / denom) saturated to 32 bits
// depends on abkf_pkg; denom must be nonzero
module abkf_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  abkf_pkg::abkf_div_req_t req,
    output logic                   done,
    output logic signed [31:0]     quot
);
    import abkf_pkg::*;

    abkf_div_state_t state_reg, state_next;

    logic [56:0] num_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        ovf_reg;
    logic [31:0] rem_reg;
    logic [32:0] low_reg;
    logic [32:0] q_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] mag;
    logic [32:0] trial;
    logic        ge;

    assign mag   = req.numer[31] ? (~req.numer + 32'd1) : req.numer;
    assign trial = {rem_reg, low_reg[32]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (req.start) state_next = DV_PRE;
            DV_PRE: begin
                if ({9'd0, num_reg[56:33]} >= den_reg) state_next = DV_DONE;
                else                                   state_next = DV_RUN;
            end
            DV_RUN:  if (cnt_reg == 6'd0) state_next = DV_DONE;
            DV_DONE: state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DV_IDLE: begin
                // half the divisor added up front gives round half away from zero
                num_reg <= {1'b0, mag, 24'd0} + {25'd0, 1'b0, req.denom[31:1]};
                den_reg <= req.denom;
                neg_reg <= req.numer[31];
            end
            DV_PRE: begin
                ovf_reg <= {9'd0, num_reg[56:33]} >= den_reg;
                rem_reg <= {8'd0, num_reg[56:33]};
                low_reg <= num_reg[32:0];
                q_reg   <= '0;
                cnt_reg <= 6'(DIV_STEPS - 1);
            end
            DV_RUN: begin
                rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                q_reg   <= {q_reg[31:0], ge};
                low_reg <= {low_reg[31:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            DV_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        done = (state_reg == DV_DONE);
        if (neg_reg) begin
            if (ovf_reg || q_reg > 33'h0_8000_0000) quot = S32_MIN;
            else                                    quot = -$signed(q_reg[31:0]);
        end else begin
            if (ovf_reg || q_reg > 33'h0_7fff_ffff) quot = S32_MAX;
            else                                    quot = $signed(q_reg[31:0]);
        end
    end

endmodule

// File: dv/testbench.sv
// testbench: self-checking bench for angle_bias_kalman_filter (angle and gyro bias filter)
// depends on abkf_pkg and the filter rtl; a built-in predictor checks every result item
module testbench;
    import abkf_pkg::*;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hff;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int  RANDOM_ITEMS = 1280;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one directed step: either an item or a register write
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           data;
        logic signed [31:0]    acc;
        logic signed [31:0]    gyro;
        logic [23:0]           dt;
        bit                    typed;     // expected angle given in the row
        logic signed [31:0]    angle;
    } plan_row_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready;
    logic signed [31:0] s_accel_angle, s_gyro_speed;
    logic [23:0] s_time_step;
    logic m_valid, m_ready;
    logic signed [31:0] m_angle_estimate;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state, shadows the filter
    logic signed [31:0] est_angle, est_bias;
    logic signed [31:0] est_cov [4];
    longint q_angle_set, q_bias_set, r_measure_set;

    logic signed [31:0] angles_due [$];
    int     mismatches = 0;
    longint cycles = 0;
    idle_mode_t idle_mode = IDLE_NONE;
    int     hold_asked = 0, hold_done = 0, hold_left = 0;

    // directed part: reset behavior, extremes, zero innovation covariance, unknown index
    plan_row_t plan [] = '{
        // fresh filter, zero step: nothing moves whatever the measurement
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh7fffffff, 32'sh0, 24'd0, 1'b1, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh80000000, 32'sh80000000, 24'd0, 1'b1, 32'sh0},
        // start angle loads the estimate; zero covariance means zero gain
        '{ROW_CFG, REG_START_ANGLE, 32'h7fffffff, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh7fffffff, 32'sh0, 24'd0, 1'b1, 32'sh7fffffff},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh0, 32'sh7fffffff, 24'hffffff, 1'b0, 32'sh0},
        // measurement noise zero: innovation covariance can be non-positive
        '{ROW_CFG, REG_R_MEASURE, 32'd0, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh80000000, 32'sh80000000, 24'hffffff, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 1'b0, 32'sh0},
        // all noise terms at their top
        '{ROW_CFG, REG_Q_ANGLE, 32'hffffffff, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_Q_BIAS, 32'h00ffffff, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_R_MEASURE, 32'h00ffffff, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh80000000, 32'sh7fffffff, 24'hffffff, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh0, 32'sh1, 24'd1, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'shffffffff, 32'sh0, 24'h800000, 1'b0, 32'sh0},
        '{ROW_CFG, REG_UNUSED, 32'h12345678, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_START_ANGLE, 32'h80000000, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh80000000, 32'sh0, 24'd0, 1'b0, 32'sh0},
        // back to the defaults
        '{ROW_CFG, REG_Q_ANGLE, 32'(Q_ANGLE_RESET), 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_Q_BIAS, 32'(Q_BIAS_RESET), 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_R_MEASURE, 32'(R_MEASURE_RESET), 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_CFG, REG_START_ANGLE, 32'h0, 32'sh0, 32'sh0, 24'd0, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'sh00010000, 32'sh00008000, 24'h010000, 1'b0, 32'sh0},
        '{ROW_ITEM, REG_Q_ANGLE, 32'd0, 32'shfff00000, 32'sh00100000, 24'h004000, 1'b0, 32'sh0}
    };

    angle_bias_kalman_filter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_angle(s_accel_angle), .s_gyro_speed(s_gyro_speed),
        .s_time_step(s_time_step),
        .m_valid(m_valid), .m_ready(m_ready), .m_angle_estimate(m_angle_estimate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // drop 24 fraction bits, half rounds up
    function automatic longint round_frac(longint x);
        longint v;
        v = x + (64'sd1 <<< 23);
        return v >>> 24;
    endfunction

    // quotient rounded half away from zero, den positive
    function automatic longint div_half_away(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // one predict/correct update of the shadow filter, returns the corrected angle
    function automatic logic signed [31:0] kalman_update(logic signed [31:0] acc,
                                                         logic signed [31:0] gyro,
                                                         logic [23:0] dt);
        longint step, p00, p01, p10, p11, rate, t, inner, y, s, k0, k1;
        step = longint'(dt);
        p00 = est_cov[0];
        p01 = est_cov[1];
        p10 = est_cov[2];
        p11 = est_cov[3];
        // predict
        rate = clip32(longint'(gyro) - longint'(est_bias));
        est_angle = clip32(longint'(est_angle) + round_frac(step * rate));
        t = round_frac(step * p11);
        inner = t - p01 - p10 + q_angle_set;
        p00 = clip32(p00 + round_frac(step * inner));
        p01 = clip32(p01 - t);
        p10 = clip32(p10 - t);
        p11 = clip32(p11 + round_frac(q_bias_set * step));
        // correct
        y = clip32(longint'(acc) - longint'(est_angle));
        s = p00 + r_measure_set;
        k0 = 0;
        k1 = 0;
        if (s > 0) begin
            k0 = clip32(div_half_away(p00 <<< 24, s));
            k1 = clip32(div_half_away(p10 <<< 24, s));
        end
        est_angle = clip32(longint'(est_angle) + round_frac(k0 * y));
        est_bias  = clip32(longint'(est_bias) + round_frac(k1 * y));
        est_cov[0] = clip32(p00 - round_frac(k0 * p00));
        est_cov[1] = clip32(p01 - round_frac(k0 * p01));
        est_cov[2] = clip32(p10 - round_frac(k1 * p00));
        est_cov[3] = clip32(p11 - round_frac(k1 * p01));
        return est_angle;
    endfunction

    function automatic bit percent(int p);
        return $urandom_range(99) < p;
    endfunction

    // wait until every result item is back, then let the sequencer settle
    task automatic drain();
        wait (angles_due.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register write, only issued with the filter drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_Q_ANGLE:     q_angle_set = longint'(value[23:0]);
            REG_Q_BIAS:      q_bias_set = longint'(value[23:0]);
            REG_R_MEASURE:   r_measure_set = longint'(value[23:0]);
            REG_START_ANGLE: est_angle = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // offer one item; typed rows carry their own expected angle
    task automatic send_item(logic signed [31:0] acc, logic signed [31:0] gyro,
                             logic [23:0] dt, bit typed, logic signed [31:0] angle);
        logic signed [31:0] predicted;
        @(negedge aclk);
        while ((idle_mode == IDLE_SENDER && percent(51)) ||
               (idle_mode == IDLE_BOTH && percent(31))) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_accel_angle = acc;
        s_gyro_speed  = gyro;
        s_time_step   = dt;
        do @(posedge aclk); while (!s_ready);
        predicted = kalman_update(acc, gyro, dt);
        angles_due.push_back(typed ? angle : predicted);
    endtask

    // pick a noise setting, extremes included
    function automatic logic [31:0] pick_noise(logic [23:0] dflt);
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'h00ffffff;
            2: return 32'(dflt);
            3: return 32'($urandom_range(1, 32'h40000));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls per mode, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready = 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            m_ready = !percent(51);
        end else if (idle_mode == IDLE_BOTH) begin
            m_ready = !percent(31);
        end else begin
            m_ready = 1'b1;
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (angles_due.size() == 0) begin
                $error("angle_estimate: unexpected item %0d", m_angle_estimate);
                mismatches++;
            end else begin
                if (m_angle_estimate !== angles_due[0]) begin
                    $error("angle_estimate: expected %0d, got %0d",
                           angles_due[0], m_angle_estimate);
                    mismatches++;
                end
                void'(angles_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] acc, gyro;
        logic [23:0] dt;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_accel_angle = '0;
        s_gyro_speed = '0;
        s_time_step = '0;
        m_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        q_angle_set = Q_ANGLE_RESET;
        q_bias_set = Q_BIAS_RESET;
        r_measure_set = R_MEASURE_RESET;
        est_angle = '0;
        est_bias = '0;
        foreach (est_cov[i]) est_cov[i] = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                @(negedge aclk);
                s_valid = 1'b0;
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].acc, plan[i].gyro, plan[i].dt, plan[i].typed, plan[i].angle);
            end
        end

        // random phases, one per idle mode, new settings in between
        for (int phase = 0; phase < 4; phase++) begin
            @(negedge aclk);
            s_valid = 1'b0;
            write_reg(REG_Q_ANGLE, pick_noise(Q_ANGLE_RESET));
            write_reg(REG_Q_BIAS, pick_noise(Q_BIAS_RESET));
            write_reg(REG_R_MEASURE, pick_noise(R_MEASURE_RESET));
            write_reg(REG_START_ANGLE, percent(50) ? $urandom : 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff));
            idle_mode = idle_mode_t'(phase);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                if (n == 40) begin
                    // long receiver hold-off while items keep coming
                    hold_asked++;
                end
                if (n == RANDOM_ITEMS / 8) begin
                    // sender waits for the pipe to empty
                    @(negedge aclk);
                    s_valid = 1'b0;
                    wait (angles_due.size() == 0);
                end
                if (percent(80)) begin
                    // plausible imu traffic: measurement near the estimate, mostly a short step
                    acc  = est_angle + $signed(32'($urandom_range(0, 32'h00ffffff))) - 32'sh007fffff;
                    gyro = $signed(32'($urandom_range(0, 32'h03ffffff))) - 32'sh01ffffff;
                    dt   = 24'($urandom_range(0, percent(90) ? 32'h00020000 : 32'h00ffffff));
                end else begin
                    acc  = $urandom;
                    gyro = $urandom;
                    dt   = 24'($urandom);
                end
                send_item(acc, gyro, dt, 1'b0, 32'sh0);
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        idle_mode = IDLE_NONE;
        wait (angles_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && angles_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
